// ===== sv/nmbd_pkg.sv =====
// Shared constants for the nonzero median block downsampler.
// No dependencies; nmbd_front, nmbd_back and the top level import this package.
package nmbd_pkg;

   // Pixel and result value width
   localparam int unsigned DEPTH_W = 16;

   // Number of value banks: one filled by the front, one ranked by the back
   localparam int unsigned NUM_BANKS = 2;

   // Result flag width on the output tuser
   localparam int unsigned FLAG_W = 1;

endpackage

// ===== sv/nmbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nmbd_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/nmbd_queue.sv =====
// Two-entry queue of finished-block descriptors (bank, value count).
// No dependencies; sits between nmbd_front and nmbd_back.
module nmbd_queue #(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;

   assign full       = fill_ff[1];
   assign head_valid = (fill_ff != 2'd0);
   assign head_data  = slot_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store descriptor
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/nmbd_front.sv =====
// Front end: accepts pixels, drops holes, writes kept values into the current bank.
// Depends on nmbd_pkg; hands finished blocks to nmbd_queue.
module nmbd_front #(
   parameter int unsigned MAX_BLOCK_VALUES = 64
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          accept,
   input  logic [nmbd_pkg::DEPTH_W-1:0]                  depth_value,
   input  logic                                          last_of_block,
   output logic                                          wr_en,
   output logic [$clog2(MAX_BLOCK_VALUES):0]             wr_addr,
   output logic [nmbd_pkg::DEPTH_W-1:0]                  wr_data,
   output logic                                          push,
   output logic [$clog2(MAX_BLOCK_VALUES+1):0]           push_data
);
   import nmbd_pkg::*;

   localparam int unsigned AW = $clog2(MAX_BLOCK_VALUES);
   localparam int unsigned CW = $clog2(MAX_BLOCK_VALUES + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          bank_ff, bank_in;
   logic          keep;
   logic [CW-1:0] count_next;

   // Keep nonzero pixels while the bank has room
   always_comb begin
      keep       = accept && (depth_value != '0) && (count_ff != CW'(MAX_BLOCK_VALUES));
      count_next = count_ff + CW'(keep);
      wr_en      = keep;
      wr_addr    = {bank_ff, count_ff[AW-1:0]};
      wr_data    = depth_value;
      push       = accept && last_of_block;
      push_data  = {bank_ff, count_next};
      count_in   = push ? '0 : count_next;
      bank_in    = bank_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         bank_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         bank_ff  <= bank_in;
      end
   end

endmodule

// ===== sv/nmbd_back.sv =====
// Back end: rank selection of the upper median over one bank, one compare per cycle.
// Depends on nmbd_pkg; reads the value RAM and drains nmbd_queue.
module nmbd_back #(
   parameter int unsigned MAX_BLOCK_VALUES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                head_valid,
   input  logic [$clog2(MAX_BLOCK_VALUES+1):0] head_data,
   output logic                                pop,
   output logic [$clog2(MAX_BLOCK_VALUES):0]   rd_addr,
   input  logic [nmbd_pkg::DEPTH_W-1:0]        rd_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [nmbd_pkg::DEPTH_W-1:0]        median_value,
   output logic                                block_empty
);
   import nmbd_pkg::*;

   localparam int unsigned AW = $clog2(MAX_BLOCK_VALUES);
   localparam int unsigned CW = $clog2(MAX_BLOCK_VALUES + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CAND  = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic               bank_ff, bank_in;
   logic [CW-1:0]      n_ff, n_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [CW-1:0]      j_ff, j_in;
   logic [CW-1:0]      below_ff, below_in;
   logic [CW-1:0]      atb_ff, atb_in;
   logic               pend_ff, pend_in;
   logic [DEPTH_W-1:0] cand_ff, cand_in;
   logic [DEPTH_W-1:0] value_ff, value_in;
   logic               empty_ff, empty_in;

   logic               head_bank;
   logic [CW-1:0]      head_count;
   logic [CW-1:0]      rank_k;
   logic [CW-1:0]      i_next;

   assign head_bank  = head_data[CW];
   assign head_count = head_data[CW-1:0];
   assign rank_k     = n_ff >> 1;
   assign i_next     = i_ff + CW'(1);

   assign rsp_tvalid   = (state_ff == ST_OUT);
   assign median_value = value_ff;
   assign block_empty  = empty_ff;

   // Sequencer: latch candidate, sweep all values counting those below it, test rank
   always_comb begin
      state_in = state_ff;
      bank_in  = bank_ff;
      n_in     = n_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      below_in = below_ff;
      atb_in   = atb_ff;
      pend_in  = 1'b0;
      cand_in  = cand_ff;
      value_in = value_ff;
      empty_in = empty_ff;
      pop      = 1'b0;
      rd_addr  = {bank_ff, j_ff[AW-1:0]};

      case (state_ff)
         ST_IDLE: begin
            rd_addr = {head_bank, {AW{1'b0}}};
            if (head_valid) begin
               bank_in = head_bank;
               n_in    = head_count;
               i_in    = '0;
               if (head_count == '0) begin
                  value_in = '0;
                  empty_in = 1'b1;
                  pop      = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_CAND;
               end
            end
         end
         ST_CAND: begin
            cand_in  = rd_data;
            j_in     = '0;
            below_in = '0;
            atb_in   = '0;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            // Count the value returned for the previous address
            if (pend_ff) begin
               below_in = below_ff + CW'(rd_data < cand_ff);
               atb_in   = atb_ff + CW'(rd_data <= cand_ff);
            end
            if (j_ff != n_ff) begin
               rd_addr = {bank_ff, j_ff[AW-1:0]};
               j_in    = j_ff + CW'(1);
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               if ((below_ff <= rank_k) && (rank_k < atb_ff)) begin
                  value_in = cand_ff;
                  empty_in = 1'b0;
                  pop      = 1'b1;
                  state_in = ST_OUT;
               end else if (i_next == n_ff) begin
                  value_in = '0;
                  empty_in = 1'b0;
                  pop      = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  rd_addr  = {bank_ff, i_next[AW-1:0]};
                  i_in     = i_next;
                  state_in = ST_CAND;
               end
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      bank_ff  <= bank_in;
      n_ff     <= n_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      below_ff <= below_in;
      atb_ff   <= atb_in;
      cand_ff  <= cand_in;
      value_ff <= value_in;
      empty_ff <= empty_in;
   end

endmodule

// ===== sv/nonzero_median_block_downsample.sv =====
// Nonzero median block downsampler. Pixels of one block enter at one per cycle while the input
// is not stalled; zero pixels are holes and are dropped, nonzero ones (up to MAX_BLOCK_VALUES per
// block) are written into one of two RAM banks. The pixel marked tlast closes the block, and the
// back end then finds the upper median (rank count/2) by taking each kept value in turn as a
// candidate and sweeping all kept values through the single RAM read port, stopping at the first
// candidate found at the median rank. An empty block yields 0 with the empty flag.
// The front keeps accepting pixels while the back works, until both banks hold closed blocks.
// Depends on nmbd_pkg, nmbd_ram, nmbd_queue, nmbd_front and nmbd_back.
module nonzero_median_block_downsample #(
   parameter int unsigned MAX_BLOCK_VALUES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [nmbd_pkg::DEPTH_W-1:0]  req_tdata,   // [15:0] depth_value
   input  logic                          req_tlast,   // last_of_block
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [nmbd_pkg::DEPTH_W-1:0]  rsp_tdata,   // [15:0] median_value
   output logic [nmbd_pkg::FLAG_W-1:0]   rsp_tuser    // [0] block_empty
);
   import nmbd_pkg::*;

   localparam int unsigned AW = $clog2(MAX_BLOCK_VALUES);
   localparam int unsigned CW = $clog2(MAX_BLOCK_VALUES + 1);
   localparam int unsigned RAM_DEPTH = NUM_BANKS * (1 << AW);

   logic               accept;
   logic               wr_en;
   logic [AW:0]        wr_addr;
   logic [DEPTH_W-1:0] wr_data;
   logic [AW:0]        rd_addr;
   logic [DEPTH_W-1:0] rd_data;
   logic               push, pop, q_full, head_valid;
   logic [CW:0]        push_data, head_data;
   logic               empty_flag;

   // Stall the input while both banks hold closed blocks
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   nmbd_front #(.MAX_BLOCK_VALUES(MAX_BLOCK_VALUES)) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .depth_value   (req_tdata),
      .last_of_block (req_tlast),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .push          (push),
      .push_data     (push_data)
   );

   nmbd_queue #(.WIDTH(CW + 1)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   nmbd_ram #(.WIDTH(DEPTH_W), .DEPTH(RAM_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nmbd_back #(.MAX_BLOCK_VALUES(MAX_BLOCK_VALUES)) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_data    (head_data),
      .pop          (pop),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .median_value (rsp_tdata),
      .block_empty  (empty_flag)
   );

   assign rsp_tuser = empty_flag;

endmodule

// ===== test/nonzero_median_block_downsample_tb.sv =====
// Self-checking testbench for nonzero_median_block_downsample: drives depth blocks over the
// request stream and checks each block's upper median against an in-bench prediction.
// Depends on nmbd_pkg and the nonzero_median_block_downsample RTL with its submodules.
module nonzero_median_block_downsample_tb;
   import nmbd_pkg::*;

   localparam int unsigned KEPT_LIMIT      = 64;
   localparam int unsigned RANDOM_ITEMS    = 870;
   localparam int unsigned STEADY_ITEMS    = 150;
   localparam int unsigned HOLD_OFF_CYCLES = 600;
   localparam int unsigned TAIL_CYCLES     = 200;
   localparam int unsigned CYCLE_LIMIT     = 1000000;

   typedef struct packed {
      logic [DEPTH_W-1:0] median;
      logic               empty;
   } block_result_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [DEPTH_W-1:0]  req_tdata  = '0;   // [15:0] depth_value
   logic                req_tlast  = 1'b0; // last_of_block
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [DEPTH_W-1:0]  rsp_tdata;         // [15:0] median_value
   logic [FLAG_W-1:0]   rsp_tuser;         // [0] block_empty

   // Predicted block state: nonzero pixels collected so far in the open block
   logic [DEPTH_W-1:0]  kept_pixels [KEPT_LIMIT];
   int unsigned         kept_count = 0;
   block_result_type    pending_medians[$];
   block_result_type    oldest_median;

   int unsigned         error_count     = 0;
   int unsigned         cycle_count     = 0;
   bit                  idling_on       = 1'b1;
   bit                  hold_off_request = 1'b0;

   nonzero_median_block_downsample #(
      .MAX_BLOCK_VALUES(KEPT_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
                  cycle_count, pending_medians.size());
         $display("nonzero_median_block_downsample_tb NOT OK");
         $finish;
      end
   end

   // Upper median (rank count/2) of the kept pixels, or the empty marker
   function automatic block_result_type block_median();
      logic [DEPTH_W-1:0] sorted [KEPT_LIMIT];
      logic [DEPTH_W-1:0] v;
      int                 j;
      block_result_type   r;
      r.median = '0;
      r.empty  = 1'b1;
      if (kept_count != 0) begin
         for (int i = 0; i < kept_count; i++) begin
            v = kept_pixels[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
               sorted[j] = sorted[j-1];
               j--;
            end
            sorted[j] = v;
         end
         r.median = sorted[kept_count / 2];
         r.empty  = 1'b0;
      end
      return r;
   endfunction

   // Update the prediction with one accepted pixel
   function automatic void predict_pixel(input logic [DEPTH_W-1:0] value, input logic last);
      if (value != '0 && kept_count < KEPT_LIMIT) begin
         kept_pixels[kept_count] = value;
         kept_count++;
      end
      if (last) begin
         pending_medians.insert(pending_medians.size(), block_median());
         kept_count = 0;
      end
   endfunction

   // Offer one pixel, with an optional idle burst first; valid stays high on return
   task automatic send_pixel(input logic [DEPTH_W-1:0] value, input logic last);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_pixel(value, last);
   endtask

   // Send one block of random pixels, the final one marked last
   task automatic send_block(input int unsigned size, input int unsigned zero_pct,
                             input bit narrow);
      logic [DEPTH_W-1:0] px;
      for (int unsigned i = 0; i < size; i++) begin
         if ($urandom_range(0, 99) < zero_pct)
            px = '0;
         else if (narrow)
            px = DEPTH_W'($urandom_range(1, 8));
         else
            px = DEPTH_W'($urandom_range(1, 65535));
         send_pixel(px, i == size - 1);
      end
   endtask

   // Drop valid and hold until every predicted result has come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_medians.size() != 0) @(posedge clock);
   endtask

   // Result sink: random stall bursts, plus one long hold-off on request
   initial begin
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_medians.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual median %h empty %b",
                     $time, rsp_tdata, rsp_tuser[0]);
            error_count++;
         end else begin
            oldest_median = pending_medians.pop_front();
            if (rsp_tdata !== oldest_median.median) begin
               $display("%0t: median mismatch: expected %h, actual %h", $time,
                        oldest_median.median, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser[0] !== oldest_median.empty) begin
               $display("%0t: empty flag mismatch: expected %b, actual %b", $time,
                        oldest_median.empty, rsp_tuser[0]);
               error_count++;
            end
         end
      end
   end

   // Blocks with no nonzero pixel, including a lone marked zero
   task automatic test_empty_blocks();
      send_pixel(16'h0000, 1'b1);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'h0000, 1'b1);
   endtask

   // Single-pixel blocks at the value extremes, and a block closed by a hole
   task automatic test_value_extremes();
      send_pixel(16'hFFFF, 1'b1);
      send_pixel(16'h0001, 1'b1);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h0001, 1'b0);
      send_pixel(16'h8000, 1'b0);
      send_pixel(16'h7FFF, 1'b0);
      send_pixel(16'h0000, 1'b1);
   endtask

   // Equal values count separately; even counts take the upper middle
   task automatic test_ties_and_even_counts();
      repeat (3) send_pixel(16'h0005, 1'b0);
      send_pixel(16'h0005, 1'b1);
      send_pixel(16'h0004, 1'b0);
      send_pixel(16'h0001, 1'b0);
      send_pixel(16'h0003, 1'b0);
      send_pixel(16'h0002, 1'b1);
      send_pixel(16'h0009, 1'b0);
      send_pixel(16'h0002, 1'b0);
      send_pixel(16'h0009, 1'b1);
   endtask

   // Overfill one block: the pixels past the store size must not move the median
   task automatic test_store_full();
      for (int i = 0; i < KEPT_LIMIT; i++)
         send_pixel(DEPTH_W'($urandom_range(1, 100)), 1'b0);
      repeat (7) send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'hFFFF, 1'b1);
      // then a block exactly at the store size
      for (int i = 0; i < KEPT_LIMIT; i++)
         send_pixel(DEPTH_W'($urandom_range(1, 65535)), i == KEPT_LIMIT - 1);
   endtask

   // Hold the result side off while blocks keep coming, so the input stalls
   task automatic test_backpressure();
      wait_for_results();
      hold_off_request = 1'b1;
      repeat (8) send_block(3, 20, 1'b0);
      wait_for_results();
   endtask

   // Random blocks, mostly short, some past the store size, some all holes
   task automatic test_random_blocks(input int unsigned item_goal);
      int unsigned sent;
      int unsigned size;
      int unsigned pick;
      int unsigned zero_pct;
      sent = 0;
      while (sent < item_goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 80)
            size = $urandom_range(1, 12);
         else if (pick < 95)
            size = $urandom_range(13, 40);
         else
            size = $urandom_range(KEPT_LIMIT - 2, KEPT_LIMIT + 16);
         pick = $urandom_range(0, 9);
         if (pick == 0)
            zero_pct = 100;
         else if (pick == 1)
            zero_pct = 90;
         else
            zero_pct = $urandom_range(0, 40);
         send_block(size, zero_pct, $urandom_range(0, 2) == 0);
         sent += size;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_empty_blocks();
      test_value_extremes();
      test_ties_and_even_counts();
      test_store_full();
      test_backpressure();
      test_random_blocks(RANDOM_ITEMS);
      // final stretch at full rate on both sides
      idling_on = 1'b0;
      test_random_blocks(STEADY_ITEMS);

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("nonzero_median_block_downsample_tb OK");
      else
         $display("nonzero_median_block_downsample_tb NOT OK");
      $finish;
   end

endmodule
